@@ hdl/obv_pkg.sv @@
// shared types, constants and register codes for the obis value extractor
`timescale 1ns / 1ps

package obv_pkg;

  localparam int NUM_CODES       = 4;
  localparam int CODE_BYTES_DEF  = 6;
  localparam int VALUE_BYTES_DEF = 4;
  localparam int CODE_REG_W      = 48;
  localparam int OFFSET_W        = 4;
  localparam int CFG_INDEX_W     = 3;
  localparam int OUT_W           = 32;

  localparam logic [CODE_REG_W-1:0] CODE_IN_PWR_RST  = 48'h0100_0107_00FF;
  localparam logic [CODE_REG_W-1:0] CODE_OUT_PWR_RST = 48'h0100_0207_00FF;
  localparam logic [CODE_REG_W-1:0] CODE_IN_TOT_RST  = 48'h0100_0108_00FF;
  localparam logic [CODE_REG_W-1:0] CODE_OUT_TOT_RST = 48'h0100_0208_00FF;
  localparam logic [OFFSET_W-1:0]   VALUE_OFFSET_RST = 4'd8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CODE_IN_PWR  = 3'd0,
    REG_CODE_OUT_PWR = 3'd1,
    REG_CODE_IN_TOT  = 3'd2,
    REG_CODE_OUT_TOT = 3'd3,
    REG_VALUE_OFFSET = 3'd4
  } obv_reg_e;

  typedef struct packed {
    logic [NUM_CODES-1:0][CODE_REG_W-1:0] code;
    logic [OFFSET_W-1:0]                  value_offset;
  } obv_cfg_t;

  typedef struct packed {
    logic             found;
    logic [OUT_W-1:0] value;
  } obv_lane_res_t;

endpackage

@@ hdl/obv_cfg_regs.sv @@
// configuration register file: four obis codes and the value offset
`timescale 1ns / 1ps

module obv_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [obv_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [obv_pkg::CODE_REG_W-1:0]      cfg_data_i,
  output obv_pkg::obv_cfg_t                   cfg_o
);

  obv_pkg::obv_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (obv_pkg::obv_reg_e'(cfg_index_i))
        obv_pkg::REG_CODE_IN_PWR:  cfg_d.code[0] = cfg_data_i;
        obv_pkg::REG_CODE_OUT_PWR: cfg_d.code[1] = cfg_data_i;
        obv_pkg::REG_CODE_IN_TOT:  cfg_d.code[2] = cfg_data_i;
        obv_pkg::REG_CODE_OUT_TOT: cfg_d.code[3] = cfg_data_i;
        obv_pkg::REG_VALUE_OFFSET:
          cfg_d.value_offset = cfg_data_i[obv_pkg::OFFSET_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.code[0]      <= obv_pkg::CODE_IN_PWR_RST;
      cfg_q.code[1]      <= obv_pkg::CODE_OUT_PWR_RST;
      cfg_q.code[2]      <= obv_pkg::CODE_IN_TOT_RST;
      cfg_q.code[3]      <= obv_pkg::CODE_OUT_TOT_RST;
      cfg_q.value_offset <= obv_pkg::VALUE_OFFSET_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/obv_matcher.sv @@
// sliding byte window and parallel compare against the four codes
`timescale 1ns / 1ps

module obv_matcher #(
  parameter int CODE_BYTES = obv_pkg::CODE_BYTES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  logic [7:0]                     byte_i,
  input  logic                           last_i,
  input  obv_pkg::obv_cfg_t              cfg_i,
  output logic [obv_pkg::NUM_CODES-1:0]  hit_o
);

  localparam int CODE_W = CODE_BYTES * 8;
  localparam int FILL_W = $clog2(CODE_BYTES + 1);

  logic [CODE_W-1:0] window_q, window_d;
  logic [FILL_W-1:0] fill_q, fill_d;

  assign window_d = CODE_W'({window_q, byte_i});
  assign fill_d   = (32'(fill_q) < CODE_BYTES) ? fill_q + FILL_W'(1) : fill_q;

  // compare against the window including the byte now arriving
  always_comb begin
    logic [CODE_W+obv_pkg::CODE_REG_W-1:0] code_ext;
    for (int i = 0; i < obv_pkg::NUM_CODES; i++) begin
      code_ext = {{CODE_W{1'b0}}, cfg_i.code[i]};
      hit_o[i] = (32'(fill_d) == CODE_BYTES) && (window_d == code_ext[CODE_W-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      fill_q   <= '0;
    end else if (step_i) begin
      if (last_i) begin
        window_q <= '0;
        fill_q   <= '0;
      end else begin
        window_q <= window_d;
        fill_q   <= fill_d;
      end
    end
  end

endmodule

@@ hdl/obv_capture_lane.sv @@
// per-code capture: countdown, value shifter and held value
`timescale 1ns / 1ps

module obv_capture_lane #(
  parameter int VALUE_BYTES = obv_pkg::VALUE_BYTES_DEF,
  parameter int CNT_W       = 5
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic [7:0]             byte_i,
  input  logic                   last_i,
  input  logic                   hit_i,
  input  logic [CNT_W-1:0]       load_i,
  output obv_pkg::obv_lane_res_t res_o
);

  localparam int SHIFT_W = VALUE_BYTES * 8;

  logic                       seen_q, seen_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d, cnt_a;
  logic [SHIFT_W-1:0]         shift_q, shift_d, shift_a;
  logic                       done_q, done_d, done_a;
  logic [obv_pkg::OUT_W-1:0]  held_q, held_d;
  logic [SHIFT_W+obv_pkg::OUT_W-1:0] shift_ext;

  always_comb begin
    // capture step on the current word
    cnt_a   = cnt_q;
    shift_a = shift_q;
    done_a  = done_q;
    if (cnt_q != '0) begin
      if (32'(cnt_q) <= VALUE_BYTES) begin
        shift_a = SHIFT_W'({shift_q, byte_i});
      end
      cnt_a = cnt_q - CNT_W'(1);
      if (cnt_a == '0) begin
        done_a = 1'b1;
      end
    end

    shift_ext = {{obv_pkg::OUT_W{1'b0}}, shift_a};
    held_d    = done_a ? shift_ext[obv_pkg::OUT_W-1:0] : held_q;

    seen_d  = seen_q;
    cnt_d   = cnt_a;
    shift_d = shift_a;
    done_d  = done_a;
    // first occurrence only
    if (hit_i && !seen_q) begin
      seen_d  = 1'b1;
      cnt_d   = load_i;
      shift_d = '0;
    end
    if (last_i) begin
      seen_d  = 1'b0;
      cnt_d   = '0;
      shift_d = '0;
      done_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
      held_q <= '0;
    end else if (step_i) begin
      seen_q <= seen_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
      if (last_i) begin
        held_q <= held_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      shift_q <= shift_d;
    end
  end

  assign res_o.found = done_a;
  assign res_o.value = held_d;

endmodule

@@ hdl/obis_value_extractor.sv @@
// top level of the obis value extractor
`timescale 1ns / 1ps

// takes a meter frame one byte per word, last_byte_i marking the final byte, and
// watches for four configurable obis codes (registers 0 to 3, first byte in the
// top bits); for the first occurrence of each code in a frame it captures the
// big-endian value whose first byte sits value_offset bytes after the byte just
// before the code (offsets not past the code mean the byte right after it). on
// the final byte one result word carries the four held values and a found flag
// per code; a missing or cut-off value keeps its previous held value with found
// at zero. throughput is one byte per clock: an input register feeds one short
// pass of window compare and capture logic, and a result register decouples the
// output, so input only stalls when a final byte meets a stalled, full result
// register. the result word is loaded as its final byte leaves the input register.
// configuration is to be written only while no frame is in flight.
module obis_value_extractor #(
  parameter int CODE_BYTES  = obv_pkg::CODE_BYTES_DEF,
  parameter int VALUE_BYTES = obv_pkg::VALUE_BYTES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [obv_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [obv_pkg::CODE_REG_W-1:0]    cfg_data_i,
  // byte input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        frame_byte_i,
  input  logic                              last_byte_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [obv_pkg::OUT_W-1:0]         input_power_w_o,
  output logic [obv_pkg::OUT_W-1:0]         output_power_w_o,
  output logic [obv_pkg::OUT_W-1:0]         total_input_wh_o,
  output logic [obv_pkg::OUT_W-1:0]         total_output_wh_o,
  output logic                              found_input_power_o,
  output logic                              found_output_power_o,
  output logic                              found_total_input_o,
  output logic                              found_total_output_o
);

  // countdown holds offset gap minus one plus the value length
  localparam int CNT_W = $clog2(16 + VALUE_BYTES);

  obv_pkg::obv_cfg_t                        cfg;
  logic [obv_pkg::NUM_CODES-1:0]            hit;
  obv_pkg::obv_lane_res_t [obv_pkg::NUM_CODES-1:0] lane_res;
  logic [CNT_W-1:0]                         load;

  // input register
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       last_q;

  logic advance;
  logic in_accept;

  // result register
  logic                                     out_valid_q;
  logic [obv_pkg::NUM_CODES-1:0][obv_pkg::OUT_W-1:0] value_q;
  logic [obv_pkg::NUM_CODES-1:0]            found_q;

  obv_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // a final byte may only move on if the result register can take it
  assign advance    = in_valid_q && !(last_q && out_valid_q && out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q <= frame_byte_i;
      last_q <= last_byte_i;
    end
  end

  // capture length after a match, from the configured offset
  always_comb begin
    if (32'(cfg.value_offset) > CODE_BYTES) begin
      load = CNT_W'(32'(cfg.value_offset) - CODE_BYTES - 1 + VALUE_BYTES);
    end else begin
      load = CNT_W'(VALUE_BYTES);
    end
  end

  obv_matcher #(
    .CODE_BYTES (CODE_BYTES)
  ) u_matcher (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (byte_q),
    .last_i (last_q),
    .cfg_i  (cfg),
    .hit_o  (hit)
  );

  for (genvar g = 0; g < obv_pkg::NUM_CODES; g++) begin : g_lane
    obv_capture_lane #(
      .VALUE_BYTES (VALUE_BYTES),
      .CNT_W       (CNT_W)
    ) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .step_i (advance),
      .byte_i (byte_q),
      .last_i (last_q),
      .hit_i  (hit[g]),
      .load_i (load),
      .res_o  (lane_res[g])
    );
  end

  // result register, loaded on a final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && last_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && last_q) begin
      for (int i = 0; i < obv_pkg::NUM_CODES; i++) begin
        value_q[i] <= lane_res[i].value;
        found_q[i] <= lane_res[i].found;
      end
    end
  end

  assign out_valid_o          = out_valid_q;
  assign input_power_w_o      = value_q[0];
  assign output_power_w_o     = value_q[1];
  assign total_input_wh_o     = value_q[2];
  assign total_output_wh_o    = value_q[3];
  assign found_input_power_o  = found_q[0];
  assign found_output_power_o = found_q[1];
  assign found_total_input_o  = found_q[2];
  assign found_total_output_o = found_q[3];

`ifndef SYNTHESIS
  // input only stalls behind a final byte facing a blocked result word
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && last_q && out_valid_o && out_stall_i))
    else $error("input stalled without a blocked final byte");

  // a final byte that moves on always produces a result word
  a_result_loaded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && last_q) |=> out_valid_o)
    else $error("final byte produced no result word");

  // no result word appears unless a final byte was processed
  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(advance && last_q) |=> (out_valid_o == $past(out_valid_o && out_stall_i)))
    else $error("result word appeared without a final byte");
`endif

endmodule
